// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define MTAT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: the consequent must hold whenever the antecedent holds.
`define MTAT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `MTAT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/mtat_pkg.sv =====
// ----------------------------------------------------------------------------
// Tracker package
// Payload types, configuration layout and constants of the power tracker.
// ----------------------------------------------------------------------------
package mtat_pkg;

  // Default window sizes and converter width.
  localparam int unsigned SLOW_WINDOW_DEF   = 4096;
  localparam int unsigned MEDIUM_WINDOW_DEF = 512;
  localparam int unsigned FAST_WINDOW_DEF   = 128;
  localparam int unsigned SAMPLE_BITS_DEF   = 12;

  // Fixed field widths.
  localparam int unsigned CODE_W   = 12;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned TIMER_W  = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 11'd2047;

  // Arm flag positions.
  localparam int unsigned ARM_FM = 0;
  localparam int unsigned ARM_FS = 1;
  localparam int unsigned ARM_FB = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_FAST_MEDIUM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_FAST_SLOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_FAST_BOUND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_BOUND_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_FRACTION       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN            = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING         = 3'd7;

  // Configuration reset values.
  localparam logic [FRAC_W-1:0]  BOUND_FRACTION_RST = 16'd62259;
  localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST  = 10'd100;
  localparam logic [FRAC_W-1:0]  STEP_GAIN_RST      = 16'd33;
  localparam logic [DUTY_W-1:0]  DUTY_CEILING_RST   = 16'd19874;

  typedef struct packed {
    logic [CODE_W-1:0] voltage_sample;
    logic [CODE_W-1:0] current_sample;
    logic [DUTY_W-1:0] prev_duty;
  } mtat_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] new_duty;
    logic              step_up;
  } mtat_out_t;

  typedef struct packed {
    logic               enable_fast_medium;
    logic               enable_fast_slow;
    logic               enable_fast_bound;
    logic               enable_bound_timeout;
    logic [FRAC_W-1:0]  bound_fraction;
    logic [LIMIT_W-1:0] timeout_limit;
    logic [FRAC_W-1:0]  step_gain;
    logic [DUTY_W-1:0]  duty_ceiling;
  } mtat_cfg_t;

  // Direction, arm flags and bound timer carried from sample to sample.
  typedef struct packed {
    logic               direction;
    logic [2:0]         armed;
    logic [TIMER_W-1:0] timer;
  } mtat_trk_t;

endpackage

// ===== hw/rtl/mppt_triple_average_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Triple-average power tracker
// Perturb-and-observe duty tracker over slow, medium and fast power windows.
// ----------------------------------------------------------------------------
// From its transfer until the next sample can be taken, a sample runs through
// a sequence of states: all three windows share one sample memory of
// SLOW_WINDOW entries, so the oldest slow, medium and fast samples are read
// one after another through its single read port, the new power is written
// back, and a final state applies the direction rules and loads the result
// register. A waiting result does not hold up the next sample until that
// sample's own result is due. No memory clearing pass runs after reset: a
// fill count marks entries that were never written, and those read as zero.
module mppt_triple_average_tracker_core #(
  parameter int unsigned SLOW_WINDOW   = mtat_pkg::SLOW_WINDOW_DEF,
  parameter int unsigned MEDIUM_WINDOW = mtat_pkg::MEDIUM_WINDOW_DEF,
  parameter int unsigned FAST_WINDOW   = mtat_pkg::FAST_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS   = mtat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mtat_pkg::mtat_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mtat_pkg::mtat_out_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mtat_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mtat_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned SW  = (SAMPLE_BITS < mtat_pkg::CODE_W) ? SAMPLE_BITS
                                                                 : mtat_pkg::CODE_W;
  localparam int unsigned PW  = 2 * SW;
  localparam int unsigned AW  = $clog2(SLOW_WINDOW);
  localparam int unsigned MSH = $clog2(MEDIUM_WINDOW);
  localparam int unsigned FSH = $clog2(FAST_WINDOW);
  localparam int unsigned SSW = PW + AW;
  localparam int unsigned MSW = PW + MSH;
  localparam int unsigned FSW = PW + FSH;
  localparam int unsigned DW  = mtat_pkg::DUTY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDM,
    S_RDF,
    S_FAST,
    S_RULE
  } state_e;

  state_e               state_q;
  logic                 out_valid_q;
  mtat_pkg::mtat_out_t  out_data_q;

  mtat_pkg::mtat_cfg_t  cfg_q;
  mtat_pkg::mtat_trk_t  trk_q;
  mtat_pkg::mtat_trk_t  trk_d;
  mtat_pkg::mtat_out_t  result;

  logic [AW-1:0]        index_q;
  logic [AW:0]          fill_q;
  logic [SSW-1:0]       slow_sum_q;
  logic [MSW-1:0]       med_sum_q;
  logic [FSW-1:0]       fast_sum_q;

  logic [PW-1:0]        power_q;
  logic [DW-1:0]        prev_q;
  logic [DW-1:0]        mag_q;
  logic                 diff_pos_q;
  logic [PW-1:0]        bound_q;

  logic                 in_xfer;
  logic                 finish;
  logic [AW-1:0]        rd_addr;
  logic [PW-1:0]        rdata;
  logic                 ram_we;

  logic [PW-1:0]        slow_old;
  logic [PW-1:0]        med_old;
  logic [PW-1:0]        fast_old;
  logic                 diff_pos;
  logic [DW-1:0]        diff;
  logic [2*DW-1:0]      step_prod;
  logic [PW+mtat_pkg::FRAC_W-1:0] bound_prod;
  logic [PW-1:0]        slow_avg;
  logic [PW-1:0]        med_avg;
  logic [PW-1:0]        fast_avg;

  // Handshake terms.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign finish      = (state_q == S_RULE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_fast_medium   <= 1'b1;
      cfg_q.enable_fast_slow     <= 1'b0;
      cfg_q.enable_fast_bound    <= 1'b0;
      cfg_q.enable_bound_timeout <= 1'b0;
      cfg_q.bound_fraction       <= mtat_pkg::BOUND_FRACTION_RST;
      cfg_q.timeout_limit        <= mtat_pkg::TIMEOUT_LIMIT_RST;
      cfg_q.step_gain            <= mtat_pkg::STEP_GAIN_RST;
      cfg_q.duty_ceiling         <= mtat_pkg::DUTY_CEILING_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mtat_pkg::REG_ENABLE_FAST_MEDIUM:   cfg_q.enable_fast_medium   <= cfg_data_i[0];
        mtat_pkg::REG_ENABLE_FAST_SLOW:     cfg_q.enable_fast_slow     <= cfg_data_i[0];
        mtat_pkg::REG_ENABLE_FAST_BOUND:    cfg_q.enable_fast_bound    <= cfg_data_i[0];
        mtat_pkg::REG_ENABLE_BOUND_TIMEOUT: cfg_q.enable_bound_timeout <= cfg_data_i[0];
        mtat_pkg::REG_BOUND_FRACTION:       cfg_q.bound_fraction       <= cfg_data_i;
        mtat_pkg::REG_TIMEOUT_LIMIT:
          cfg_q.timeout_limit <= cfg_data_i[mtat_pkg::LIMIT_W-1:0];
        mtat_pkg::REG_STEP_GAIN:            cfg_q.step_gain            <= cfg_data_i;
        mtat_pkg::REG_DUTY_CEILING:         cfg_q.duty_ceiling         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Read address: the entry written one slow, medium and fast window ago.
  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr = index_q;
      S_RDM:   rd_addr = index_q - AW'(MEDIUM_WINDOW);
      default: rd_addr = index_q - AW'(FAST_WINDOW);
    endcase
  end

  assign ram_we = (state_q == S_FAST);

  mtat_sample_ram #(
    .DEPTH (SLOW_WINDOW),
    .WIDTH (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (index_q),
    .wdata_i (power_q),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Entries never written read as zero.
  assign slow_old = (fill_q >= (AW+1)'(SLOW_WINDOW))   ? rdata : '0;
  assign med_old  = (fill_q >= (AW+1)'(MEDIUM_WINDOW)) ? rdata : '0;
  assign fast_old = (fill_q >= (AW+1)'(FAST_WINDOW))   ? rdata : '0;

  // Averages are the upper bits of the running sums.
  assign slow_avg = slow_sum_q[AW +: PW];
  assign med_avg  = med_sum_q[MSH +: PW];
  assign fast_avg = fast_sum_q[FSH +: PW];

  // Step magnitude and lower bound products.
  assign diff_pos   = (cfg_q.duty_ceiling >= prev_q);
  assign diff       = diff_pos ? (cfg_q.duty_ceiling - prev_q) : (prev_q - cfg_q.duty_ceiling);
  assign step_prod  = diff * cfg_q.step_gain;
  assign bound_prod = slow_avg * cfg_q.bound_fraction;

  // Running sums, sample index and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_sum_q <= '0;
      med_sum_q  <= '0;
      fast_sum_q <= '0;
      index_q    <= '0;
      fill_q     <= '0;
      trk_q      <= '0;
    end else begin
      if (state_q == S_RDM) begin
        slow_sum_q <= slow_sum_q - SSW'(slow_old) + SSW'(power_q);
      end
      if (state_q == S_RDF) begin
        med_sum_q <= med_sum_q - MSW'(med_old) + MSW'(power_q);
      end
      if (state_q == S_FAST) begin
        fast_sum_q <= fast_sum_q - FSW'(fast_old) + FSW'(power_q);
        index_q    <= index_q + 1'b1;
        if (fill_q != (AW+1)'(SLOW_WINDOW)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (finish) begin
        trk_q <= trk_d;
      end
    end
  end

  // Per-sample datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      power_q <= in_data_i.voltage_sample[SW-1:0] * in_data_i.current_sample[SW-1:0];
      prev_q  <= in_data_i.prev_duty;
    end
    if (state_q == S_RDM) begin
      mag_q      <= step_prod[2*DW-1:DW];
      diff_pos_q <= diff_pos;
    end
    if (state_q == S_RDF) begin
      bound_q <= bound_prod[PW+mtat_pkg::FRAC_W-1:mtat_pkg::FRAC_W];
    end
  end

  mtat_decide #(
    .PW (PW)
  ) u_decide (
    .cfg_i       (cfg_q),
    .trk_i       (trk_q),
    .slow_avg_i  (slow_avg),
    .med_avg_i   (med_avg),
    .fast_avg_i  (fast_avg),
    .bound_i     (bound_q),
    .prev_duty_i (prev_q),
    .mag_i       (mag_q),
    .diff_pos_i  (diff_pos_q),
    .trk_o       (trk_d),
    .out_o       (result)
  );

  // Sequencer and result register. A result leaving in the same cycle as
  // the next one is loaded keeps the valid flag set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_RDM;
          end
        end
        S_RDM:  state_q <= S_RDF;
        S_RDF:  state_q <= S_FAST;
        S_FAST: state_q <= S_RULE;
        S_RULE: begin
          if (finish) begin
            out_valid_q <= 1'b1;
            out_data_q  <= result;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A transfer on the input starts the memory read sequence.
  `MTAT_ASSERT_IMPL(a_start_seq, clk_i, rst_ni, in_xfer, ##1 (state_q == S_RDM),
                    "no read sequence after input transfer")
  // The fill count never passes the window size.
  `MTAT_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= (AW+1)'(SLOW_WINDOW),
               "fill count overflow")
  // Each write-back moves the sample index by exactly one.
  `MTAT_ASSERT_IMPL(a_index_step, clk_i, rst_ni, state_q == S_FAST,
                    ##1 (index_q == AW'($past(index_q) + 1'b1)),
                    "sample index did not advance")
  // A new result appears only from the decision state.
  `MTAT_ASSERT_IMPL(a_result_src, clk_i, rst_ni, $rose(out_valid_q),
                    $past(state_q == S_RULE), "result without a decision")

endmodule

// ===== hw/rtl/mtat_sample_ram.sv =====
// ----------------------------------------------------------------------------
// Sample memory
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mtat_sample_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mtat_decide.sv =====
// ----------------------------------------------------------------------------
// Direction and duty decision
// Applies the crossing rules to the averages and computes the next duty.
// ----------------------------------------------------------------------------
module mtat_decide #(
  parameter int unsigned PW = 24
) (
  input  mtat_pkg::mtat_cfg_t               cfg_i,
  input  mtat_pkg::mtat_trk_t               trk_i,
  input  logic [PW-1:0]                     slow_avg_i,
  input  logic [PW-1:0]                     med_avg_i,
  input  logic [PW-1:0]                     fast_avg_i,
  input  logic [PW-1:0]                     bound_i,
  input  logic [mtat_pkg::DUTY_W-1:0]       prev_duty_i,
  input  logic [mtat_pkg::DUTY_W-1:0]       mag_i,
  input  logic                              diff_pos_i,
  output mtat_pkg::mtat_trk_t               trk_o,
  output mtat_pkg::mtat_out_t               out_o
);

  mtat_pkg::mtat_trk_t             trk;
  logic [mtat_pkg::DUTY_W:0]       duty_sum;
  logic [mtat_pkg::DUTY_W:0]       duty_dif;
  logic                            up;

  // Crossing rules in fixed order, then the timer, then rearming.
  always_comb begin
    trk = trk_i;
    if (cfg_i.enable_fast_medium && (med_avg_i > fast_avg_i) &&
        !trk.armed[mtat_pkg::ARM_FM]) begin
      trk.armed[mtat_pkg::ARM_FM] = 1'b1;
      trk.direction = ~trk.direction;
    end
    if (cfg_i.enable_fast_slow && (slow_avg_i > fast_avg_i) &&
        !trk.armed[mtat_pkg::ARM_FS]) begin
      trk.armed[mtat_pkg::ARM_FS] = 1'b1;
      trk.direction = ~trk.direction;
    end
    if (cfg_i.enable_fast_bound && (bound_i > fast_avg_i) &&
        !trk.armed[mtat_pkg::ARM_FB] &&
        (trk.timer > {1'b0, cfg_i.timeout_limit})) begin
      trk.armed[mtat_pkg::ARM_FB] = 1'b1;
      trk.timer = '0;
      trk.direction = ~trk.direction;
    end
    if (cfg_i.enable_bound_timeout && (bound_i < fast_avg_i) &&
        (trk.timer < mtat_pkg::TIMER_MAX)) begin
      trk.timer = trk.timer + 1'b1;
    end
    if (bound_i < fast_avg_i) begin
      trk.armed[mtat_pkg::ARM_FS] = 1'b0;
      trk.armed[mtat_pkg::ARM_FB] = 1'b0;
    end
    if (med_avg_i < fast_avg_i) begin
      trk.armed[mtat_pkg::ARM_FM] = 1'b0;
    end
  end

  // Duty step with saturation at both ends of the 16-bit range.
  always_comb begin
    duty_sum = {1'b0, prev_duty_i} + {1'b0, mag_i};
    duty_dif = {1'b0, prev_duty_i} - {1'b0, mag_i};
    up = (trk.direction == diff_pos_i);
    if (up) begin
      out_o.new_duty = duty_sum[mtat_pkg::DUTY_W] ? '1 : duty_sum[mtat_pkg::DUTY_W-1:0];
    end else begin
      out_o.new_duty = duty_dif[mtat_pkg::DUTY_W] ? '0 : duty_dif[mtat_pkg::DUTY_W-1:0];
    end
    out_o.step_up = trk.direction;
  end

  assign trk_o = trk;

endmodule
